// File: hdl/mm64_pkg.sv
package mm64_pkg;

	localparam int FIELD_W = 64;
	localparam int STATUS_W = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_QUOT_OVF = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_MOD_ZERO = 2'd2;

	typedef struct packed {
		logic [FIELD_W-1:0] operand_a;
		logic [FIELD_W-1:0] operand_b;
		logic [FIELD_W-1:0] modulus;
	} item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] remainder;
		logic [STATUS_W-1:0] status;
	} result_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} link_t;

endpackage

// File: hdl/mm64_front.sv
module mm64_front #(
	parameter int W = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mm64_pkg::item_t   item,
	output logic              full,
	output logic              fwd_valid,
	input  logic              fwd_ready,
	output logic [3*W:0]      fwd_data
);

	logic          valid_q;
	logic [3*W:0]  data_q;
	logic          accept;

	assign full = valid_q && !fwd_ready;
	assign accept = push && !full;
	assign fwd_valid = valid_q;
	assign fwd_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (fwd_ready) begin
			valid_q <= 1'b0;
		end
	end

	// A zero modulus is flagged here so the back end needs no wide compare for it.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= {(item.modulus[W-1:0] == '0), item.modulus[W-1:0],
				item.operand_b[W-1:0], item.operand_a[W-1:0]};
		end
	end

endmodule

// File: hdl/mm64_queue.sv
module mm64_queue #(
	parameter int DW = 193
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  logic [DW-1:0] wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0]                 mem_q [mm64_pkg::QUEUE_DEPTH];
	logic [mm64_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [mm64_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [mm64_pkg::QUEUE_AW:0]   count_q;
	logic                          do_wr;
	logic                          do_rd;

	assign wr_ready = (count_q != (mm64_pkg::QUEUE_AW+1)'(mm64_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: hdl/mm64_back.sv
module mm64_back #(
	parameter int W = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  logic [3*W:0]        q_data,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output mm64_pkg::result_t   result
);

	localparam int H = (W + 1) / 2;
	localparam int HI = W - H;
	localparam int NSTEP = 2 * W;

	logic en;

	logic [W-1:0] a_in;
	logic [W-1:0] b_in;

	logic            v_s1;
	logic [2*H-1:0]  p00_s1;
	logic [W-1:0]    p01_s1;
	logic [W-1:0]    p10_s1;
	logic [2*HI-1:0] p11_s1;
	logic [W-1:0]    m_s1;
	logic            z_s1;

	logic            v_s2;
	logic [2*H-1:0]  p00_s2;
	logic [W:0]      mid_s2;
	logic [2*HI-1:0] p11_s2;
	logic [W-1:0]    m_s2;
	logic            z_s2;

	logic            v_s3;
	logic [2*W-1:0]  prod_s3;
	logic [W-1:0]    m_s3;
	logic            z_s3;

	logic            v_q    [NSTEP+1];
	logic [W-1:0]    rem_q  [NSTEP+1];
	logic [2*W-1:0]  prod_q [NSTEP+1];
	logic [W-1:0]    m_q    [NSTEP+1];
	logic            z_q    [NSTEP+1];
	logic            ovf_q  [NSTEP+1];

	logic              out_valid_q;
	mm64_pkg::result_t out_q;

	assign en = !out_valid_q || pop;
	assign q_pop = en && q_valid;
	assign empty = !out_valid_q;
	assign result = out_q;

	assign a_in = q_data[W-1:0];
	assign b_in = q_data[2*W-1:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_q[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= a_in[H-1:0] * b_in[H-1:0];
			p01_s1 <= a_in[H-1:0] * b_in[W-1:H];
			p10_s1 <= a_in[W-1:H] * b_in[H-1:0];
			p11_s1 <= a_in[W-1:H] * b_in[W-1:H];
			m_s1 <= q_data[3*W-1:2*W];
			z_s1 <= q_data[3*W];

			p00_s2 <= p00_s1;
			mid_s2 <= {1'b0, p01_s1} + {1'b0, p10_s1};
			p11_s2 <= p11_s1;
			m_s2 <= m_s1;
			z_s2 <= z_s1;

			prod_s3 <= {p11_s2, p00_s2} + ((2*W)'(mid_s2) << H);
			m_s3 <= m_s2;
			z_s3 <= z_s2;

			rem_q[0] <= '0;
			prod_q[0] <= prod_s3;
			m_q[0] <= m_s3;
			z_q[0] <= z_s3;
			ovf_q[0] <= (prod_s3[2*W-1:W] >= m_s3);
		end
	end

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		logic [W:0] shifted;
		logic [W:0] diff;
		logic       take;

		assign shifted = {rem_q[k], prod_q[k][2*W-1]};
		assign take = (shifted >= {1'b0, m_q[k]});
		assign diff = shifted - {1'b0, m_q[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1] <= take ? diff[W-1:0] : shifted[W-1:0];
				prod_q[k+1] <= prod_q[k] << 1;
				m_q[k+1] <= m_q[k];
				z_q[k+1] <= z_q[k];
				ovf_q[k+1] <= ovf_q[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_q[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (z_q[NSTEP]) begin
				out_q.remainder <= '0;
				out_q.status <= mm64_pkg::STATUS_MOD_ZERO;
			end else if (ovf_q[NSTEP]) begin
				out_q.remainder <= mm64_pkg::FIELD_W'(rem_q[NSTEP]);
				out_q.status <= mm64_pkg::STATUS_QUOT_OVF;
			end else begin
				out_q.remainder <= mm64_pkg::FIELD_W'(rem_q[NSTEP]);
				out_q.status <= mm64_pkg::STATUS_OK;
			end
		end
	end

endmodule

// File: hdl/modular_multiply_64_core.sv
// Modular multiplier: each request carries two multiplicands and a modulus, masked to
// OPERAND_WIDTH bits, and yields one result with the exact remainder of the full product
// and a status (quotient overflow, or zero modulus with a zero remainder). A new request is
// taken every cycle while results are popped. A three-stage split multiplier feeds a
// restoring division that retires one product bit per pipeline stage. The pipeline holds
// only while the result register is full and not popped; a four-entry queue decouples the
// input side.
module modular_multiply_64_core #(
	parameter int OPERAND_WIDTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  mm64_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output mm64_pkg::result_t result
);

	localparam int DW = 3 * OPERAND_WIDTH + 1;

	mm64_pkg::link_t fwd;
	mm64_pkg::link_t bck;
	logic [DW-1:0]   fwd_data;
	logic [DW-1:0]   bck_data;

	mm64_front #(.W(OPERAND_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.fwd_valid (fwd.valid),
		.fwd_ready (fwd.ready),
		.fwd_data  (fwd_data)
	);

	mm64_queue #(.DW(DW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fwd.valid),
		.wr_ready (fwd.ready),
		.wr_data  (fwd_data),
		.rd_valid (bck.valid),
		.rd_ready (bck.ready),
		.rd_data  (bck_data)
	);

	mm64_back #(.W(OPERAND_WIDTH)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (bck.valid),
		.q_data  (bck_data),
		.q_pop   (bck.ready),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

`ifndef SYNTHESIS
	a_no_status3: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.status == mm64_pkg::STATUS_OK ||
			result.status == mm64_pkg::STATUS_QUOT_OVF ||
			result.status == mm64_pkg::STATUS_MOD_ZERO))
		else $error("illegal status code");

	a_zero_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status == mm64_pkg::STATUS_MOD_ZERO) |-> (result.remainder == '0))
		else $error("zero modulus with nonzero remainder");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while not popped");
`endif

endmodule
